/* hdl/nnt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnt_pkg: shared types and constants for the nearest-neighbor tour engine
// Port widths, configuration defaults, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package nnt_pkg;

    // fixed port field widths
    localparam int CITY_W     = 4;
    localparam int POS_W      = 5;
    localparam int TOTAL_W    = 20;
    localparam int DIST_IN_W  = 16;
    localparam int NCFG_W     = 5;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 20'hF_FFFF;
    localparam logic [NCFG_W-1:0]  NCITIES_RESET = 5'd4;

    // defaults for the top-level parameters
    localparam int MAX_CITIES_DEF = 16;
    localparam int DIST_WIDTH_DEF = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_MOVE,
        S_RET_RD,
        S_FINAL
    } state_t;

endpackage
`default_nettype wire

/* hdl/nnt_dist_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnt_dist_mem: distance table storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module nnt_dist_mem #(
    parameter int DEPTH = nnt_pkg::MAX_CITIES_DEF * nnt_pkg::MAX_CITIES_DEF,
    parameter int WIDTH = nnt_pkg::DIST_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hdl/nearest_neighbour_tour.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbour_tour: greedy nearest-neighbor tour over a loaded table
// Loads fill a square distance table; a run request walks the table from
// city 0, always moving to the closest unvisited city, then back to city 0.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_stall  operation, row_city, col_city, distance
//  out      out_valid/ out_stall route_city, route_position, total_length, last
//  cfg      cfg_valid/ cfg_ready cfg_data (n_cities)
//
//  A load request writes one table entry if it falls inside the table.
//  A run request keeps in_stall high until its closing result is loaded,
//  output stalls included: every move scans n candidates through the single
//  table read port (one read per cycle), one compare unit picks the best.
//  Each result leaves through one output register; a stalled result holds
//  the sequencer until the register frees up.
//  rst_n clears control state; table contents are undefined until loaded.
//
// ----------------------------------------------------------------------------
module nearest_neighbour_tour #(
    parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
    parameter int DIST_WIDTH = nnt_pkg::DIST_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               operation,
    input  wire logic [nnt_pkg::CITY_W-1:0]         row_city,
    input  wire logic [nnt_pkg::CITY_W-1:0]         col_city,
    input  wire logic [nnt_pkg::DIST_IN_W-1:0]      distance,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [nnt_pkg::CITY_W-1:0]         route_city,
    output logic      [nnt_pkg::POS_W-1:0]          route_position,
    output logic      [nnt_pkg::TOTAL_W-1:0]        total_length,
    output logic                                    last,
    // configuration channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [nnt_pkg::NCFG_W-1:0]         cfg_data
);

    localparam int CW    = $clog2(MAX_CITIES);             // city index
    localparam int NW    = $clog2(MAX_CITIES + 1);         // city count
    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = DIST_WIDTH + $clog2(MAX_CITIES + 1);
    localparam int EXT_W = (SUM_W > nnt_pkg::TOTAL_W) ? SUM_W : nnt_pkg::TOTAL_W;

    // saturate the running sum onto the 20-bit length port
    function automatic logic [nnt_pkg::TOTAL_W-1:0] sat_total(input logic [SUM_W-1:0] s);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(s);
        if (ext > EXT_W'(nnt_pkg::TOTAL_MAX))
            return nnt_pkg::TOTAL_MAX;
        else
            return nnt_pkg::TOTAL_W'(ext);
    endfunction

    // ---------------------------------------------------------------- state
    nnt_pkg::state_t         state_reg, state_next;
    logic [nnt_pkg::NCFG_W-1:0] n_cities_reg;
    logic [NW-1:0]           n_run_reg, n_run_next;
    logic [NW-1:0]           step_reg, step_next;
    logic [CW-1:0]           cand_reg, cand_next;
    logic [CW-1:0]           cur_reg, cur_next;
    logic [AW-1:0]           cur_base_reg, cur_base_next;
    logic [MAX_CITIES-1:0]   visited_reg, visited_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [CW-1:0]           rd_cand_reg, rd_cand_next;
    logic                    best_found_reg, best_found_next;
    logic [CW-1:0]           best_reg, best_next;
    logic [DIST_WIDTH-1:0]   best_d_reg, best_d_next;
    logic                    out_valid_reg, out_valid_next;

    // result register payload
    logic [nnt_pkg::CITY_W-1:0]  route_city_reg, route_city_next;
    logic [nnt_pkg::POS_W-1:0]   route_pos_reg, route_pos_next;
    logic [nnt_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        last_reg, last_next;
    logic                        out_load;

    // table port
    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    logic [DIST_WIDTH-1:0]   mem_wr_data;
    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    logic [DIST_WIDTH-1:0]   mem_rd_data;

    logic                    in_accept;
    logic                    out_free;
    logic                    load_in_range;
    logic [NW-1:0]           n_clamped;
    logic [SUM_W-1:0]        sum_move;
    logic [SUM_W-1:0]        sum_ret;

    nnt_dist_mem #(
        .DEPTH (DEPTH),
        .WIDTH (DIST_WIDTH),
        .AW    (AW)
    ) u_dist_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_stall  = (state_reg != nnt_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = (state_reg == nnt_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign route_city     = route_city_reg;
    assign route_position = route_pos_reg;
    assign total_length   = total_reg;
    assign last           = last_reg;

    // loads outside the parameterized table are dropped
    assign load_in_range = (32'(row_city) < MAX_CITIES) && (32'(col_city) < MAX_CITIES);

    // city count clamped into 2..MAX_CITIES
    always_comb
    begin
        if (32'(n_cities_reg) < 2)
            n_clamped = NW'(2);
        else if (32'(n_cities_reg) > MAX_CITIES)
            n_clamped = NW'(MAX_CITIES);
        else
            n_clamped = NW'(n_cities_reg);
    end

    assign sum_move = sum_reg + SUM_W'(best_d_reg);
    assign sum_ret  = sum_reg + SUM_W'(mem_rd_data);

    assign mem_wr_en   = in_accept && (operation == nnt_pkg::OP_LOAD) && load_in_range;
    assign mem_wr_addr = AW'(32'(row_city) * MAX_CITIES + 32'(col_city));
    assign mem_wr_data = DIST_WIDTH'(distance);

    // ----------------------------------------------------------- sequencer
    always_comb
    begin
        state_next      = state_reg;
        n_run_next      = n_run_reg;
        step_next       = step_reg;
        cand_next       = cand_reg;
        cur_next        = cur_reg;
        cur_base_next   = cur_base_reg;
        visited_next    = visited_reg;
        sum_next        = sum_reg;
        rd_pend_next    = 1'b0;
        rd_cand_next    = rd_cand_reg;
        best_found_next = best_found_reg;
        best_next       = best_reg;
        best_d_next     = best_d_reg;
        out_load        = 1'b0;
        route_city_next = route_city_reg;
        route_pos_next  = route_pos_reg;
        total_next      = total_reg;
        last_next       = last_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = cur_base_reg + AW'(cand_reg);

        // shared compare unit: one candidate per cycle, strict less keeps
        // the lowest index on ties
        if (rd_pend_reg)
        begin
            if (!best_found_reg || (mem_rd_data < best_d_reg))
            begin
                best_found_next = 1'b1;
                best_next       = rd_cand_reg;
                best_d_next     = mem_rd_data;
            end
        end

        unique case (state_reg)
            nnt_pkg::S_IDLE:
            begin
                if (in_accept && (operation == nnt_pkg::OP_RUN))
                begin
                    n_run_next    = n_clamped;
                    step_next     = NW'(1);
                    cur_next      = '0;
                    cur_base_next = '0;
                    visited_next  = MAX_CITIES'(1);
                    sum_next      = '0;
                    state_next    = nnt_pkg::S_START;
                end
            end

            nnt_pkg::S_START:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    route_city_next = '0;
                    route_pos_next  = '0;
                    total_next      = '0;
                    last_next       = 1'b0;
                    cand_next       = '0;
                    best_found_next = 1'b0;
                    state_next      = nnt_pkg::S_SCAN;
                end
            end

            nnt_pkg::S_SCAN:
            begin
                mem_rd_en    = 1'b1;
                rd_pend_next = !visited_reg[cand_reg];
                rd_cand_next = cand_reg;
                cand_next    = cand_reg + CW'(1);
                if (NW'(cand_reg) == n_run_reg - NW'(1))
                begin
                    state_next = nnt_pkg::S_DRAIN;
                end
            end

            nnt_pkg::S_DRAIN:
            begin
                state_next = nnt_pkg::S_MOVE;
            end

            nnt_pkg::S_MOVE:
            begin
                if (out_free)
                begin
                    out_load              = 1'b1;
                    route_city_next       = nnt_pkg::CITY_W'(best_reg);
                    route_pos_next        = nnt_pkg::POS_W'(step_reg);
                    total_next            = sat_total(sum_move);
                    last_next             = 1'b0;
                    visited_next[best_reg] = 1'b1;
                    sum_next              = sum_move;
                    cur_next              = best_reg;
                    cur_base_next         = AW'(32'(best_reg) * MAX_CITIES);
                    cand_next             = '0;
                    best_found_next       = 1'b0;
                    if (step_reg == n_run_reg - NW'(1))
                    begin
                        state_next = nnt_pkg::S_RET_RD;
                    end
                    else
                    begin
                        step_next  = step_reg + NW'(1);
                        state_next = nnt_pkg::S_SCAN;
                    end
                end
            end

            nnt_pkg::S_RET_RD:
            begin
                // closing leg back to city 0
                mem_rd_en   = 1'b1;
                mem_rd_addr = cur_base_reg;
                state_next  = nnt_pkg::S_FINAL;
            end

            nnt_pkg::S_FINAL:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    route_city_next = '0;
                    route_pos_next  = nnt_pkg::POS_W'(n_run_reg);
                    total_next      = sat_total(sum_ret);
                    last_next       = 1'b1;
                    sum_next        = sum_ret;
                    cur_next        = '0;
                    state_next      = nnt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = nnt_pkg::S_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nnt_pkg::S_IDLE;
            n_cities_reg   <= nnt_pkg::NCITIES_RESET;
            n_run_reg      <= NW'(2);
            step_reg       <= '0;
            cand_reg       <= '0;
            cur_reg        <= '0;
            cur_base_reg   <= '0;
            visited_reg    <= '0;
            sum_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_run_reg      <= n_run_next;
            step_reg       <= step_next;
            cand_reg       <= cand_next;
            cur_reg        <= cur_next;
            cur_base_reg   <= cur_base_next;
            visited_reg    <= visited_next;
            sum_reg        <= sum_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                n_cities_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_cand_reg    <= rd_cand_next;
        best_reg       <= best_next;
        best_d_reg     <= best_d_next;
        route_city_reg <= route_city_next;
        route_pos_reg  <= route_pos_next;
        total_reg      <= total_next;
        last_reg       <= last_next;
    end

    // ----------------------------------------------------------- assertions
    // one visited city per tour position already placed
    a_visited_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nnt_pkg::S_SCAN) |-> ($countones(visited_reg) == int'(step_reg)))
        else $error("visited map out of step with tour position");

    // a move always has an unvisited candidate
    a_best_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nnt_pkg::S_MOVE) |-> best_found_reg)
        else $error("move without a candidate");

    // scan never runs past the active city count
    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nnt_pkg::S_SCAN) |-> (NW'(cand_reg) < n_run_reg))
        else $error("candidate beyond city count");

    // the closing result returns to city 0 and ends the run
    a_last_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nnt_pkg::S_FINAL && out_free) |=>
            (out_valid_reg && last_reg && route_city_reg == '0
             && state_reg == nnt_pkg::S_IDLE))
        else $error("final result malformed");

    // start city is always marked during a run
    a_home_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nnt_pkg::S_IDLE) |-> visited_reg[0])
        else $error("start city not marked visited");

endmodule
`default_nettype wire

/* tb/sv/nnt_tour_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_tour_checker: scoreboard for the nearest-neighbor tour engine
// Snoops the request, result and config channels, plans each greedy tour
// from its own table copy and compares every accepted result against it.
// ----------------------------------------------------------------------------
module nnt_tour_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          operation,
    input  logic [nnt_pkg::CITY_W-1:0]    row_city,
    input  logic [nnt_pkg::CITY_W-1:0]    col_city,
    input  logic [nnt_pkg::DIST_IN_W-1:0] distance,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [nnt_pkg::CITY_W-1:0]    route_city,
    input  logic [nnt_pkg::POS_W-1:0]     route_position,
    input  logic [nnt_pkg::TOTAL_W-1:0]   total_length,
    input  logic                          last,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [nnt_pkg::NCFG_W-1:0]    cfg_data,
    output int                            mismatch_count,
    output int                            route_steps_left,
    output int                            route_steps_checked
);
    import nnt_pkg::*;

    localparam int CITIES = MAX_CITIES_DEF;

    typedef struct packed {
        logic [CITY_W-1:0]  city;
        logic [POS_W-1:0]   pos;
        logic [TOTAL_W-1:0] total;
        logic               fin;
    } route_step_t;

    logic [DIST_IN_W-1:0] dist_tab [0:CITIES*CITIES-1];
    route_step_t          expected_route [$];
    logic [NCFG_W-1:0]    city_count;
    int                   miss_cnt;
    int                   good_cnt;

    function automatic int unsigned clamp_cities(input int unsigned v);
        if (v < 2)
            return 2;
        if (v > CITIES)
            return CITIES;
        return v;
    endfunction

    function automatic void add_step(input int unsigned city, input int unsigned pos,
                                     input int unsigned sum, input bit fin);
        route_step_t s;
        s.city  = city[CITY_W-1:0];
        s.pos   = pos[POS_W-1:0];
        s.total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        s.fin   = fin;
        expected_route.insert(expected_route.size(), s);
    endfunction

    // greedy walk from city 0; strict less-than keeps the lowest index on ties
    function automatic void plan_greedy_tour(input int unsigned n);
        logic [CITIES-1:0] visited;
        int unsigned       here;
        int unsigned       best;
        int unsigned       best_d;
        int unsigned       d;
        int unsigned       sum;
        bit                found;
        visited = CITIES'(1);
        here    = 0;
        sum     = 0;
        add_step(0, 0, 0, 1'b0);
        for (int unsigned step = 1; step < n; step++)
        begin
            found  = 1'b0;
            best   = 0;
            best_d = 0;
            for (int unsigned cand = 0; cand < n; cand++)
            begin
                if (!visited[cand])
                begin
                    d = dist_tab[here*CITIES + cand];
                    if (!found || d < best_d)
                    begin
                        found  = 1'b1;
                        best   = cand;
                        best_d = d;
                    end
                end
            end
            visited[best] = 1'b1;
            sum  += best_d;
            here  = best;
            add_step(best, step, sum, 1'b0);
        end
        sum += dist_tab[here*CITIES];
        add_step(0, n, sum, 1'b1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        route_step_t want;
        if (!rst_n)
        begin
            expected_route.delete();
            city_count = NCITIES_RESET;
            for (int i = 0; i < CITIES*CITIES; i++)
                dist_tab[i] = '0;
            miss_cnt = 0;
            good_cnt = 0;
            mismatch_count      <= 0;
            route_steps_left    <= 0;
            route_steps_checked <= 0;
        end
        else
        begin
            // results first: nothing leaving now belongs to a run taken at this edge
            if (out_valid && !out_stall)
            begin
                if (expected_route.size() == 0)
                begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display("%0t: unexpected result city %0d pos %0d total %0d last %0b",
                                 $time, route_city, route_position, total_length, last);
                end
                else
                begin
                    want = expected_route.pop_front();
                    good_cnt++;
                    if (route_city !== want.city || route_position !== want.pos ||
                        total_length !== want.total || last !== want.fin)
                    begin
                        miss_cnt++;
                        if (miss_cnt <= 10)
                            $display({"%0t: mismatch exp city %0d pos %0d total %0d last %0b,",
                                      " got city %0d pos %0d total %0d last %0b"},
                                     $time, want.city, want.pos, want.total, want.fin,
                                     route_city, route_position, total_length, last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                city_count = cfg_data;
            if (in_valid && !in_stall)
            begin
                // row and column are 4 bits wide, so every load lands in the table
                if (op_t'(operation) == OP_LOAD)
                    dist_tab[{row_city, col_city}] = distance;
                else
                    plan_greedy_tour(clamp_cities(city_count));
            end
            mismatch_count      <= miss_cnt;
            route_steps_left    <= expected_route.size();
            route_steps_checked <= good_cnt;
        end
    end

endmodule

/* tb/sv/tb_nearest_neighbour_tour.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbour_tour: stimulus and verdict for the tour engine
// Loads distance tables, runs tours over a range of city counts and lets
// the checker compare every route step; bursty requests, patterned stalls.
// ----------------------------------------------------------------------------
module tb_nearest_neighbour_tour;
    import nnt_pkg::*;

    localparam int CITIES        = MAX_CITIES_DEF;
    localparam int ITEMS_TARGET  = 460;
    // extra cycles settle() waits after the last predicted step drains
    localparam int SETTLE_CYCLES = 16;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 operation = 1'b0;
    logic [CITY_W-1:0]    row_city  = '0;
    logic [CITY_W-1:0]    col_city  = '0;
    logic [DIST_IN_W-1:0] distance  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CITY_W-1:0]    route_city;
    logic [POS_W-1:0]     route_position;
    logic [TOTAL_W-1:0]   total_length;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [NCFG_W-1:0]    cfg_data  = '0;

    int mismatch_count;
    int route_steps_left;
    int route_steps_checked;

    // stimulus bookkeeping
    bit [CITIES*CITIES-1:0] loaded;      // table entries written so far
    int                     burst_left;  // requests left in the current burst
    int                     items_sent;
    int                     tours_sent;
    int unsigned            n_now;       // effective city count in the engine
    int unsigned            n_lo;
    int unsigned            n_hi;

    // receiver stall pattern state
    int rx_mode;
    int rx_mode_left;
    int rx_hold;

    always #4 clk = ~clk;

    nearest_neighbour_tour u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .row_city       (row_city),
        .col_city       (col_city),
        .distance       (distance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .route_city     (route_city),
        .route_position (route_position),
        .total_length   (total_length),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    nnt_tour_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .operation           (operation),
        .row_city            (row_city),
        .col_city            (col_city),
        .distance            (distance),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .route_city          (route_city),
        .route_position      (route_position),
        .total_length        (total_length),
        .last                (last),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .route_steps_left    (route_steps_left),
        .route_steps_checked (route_steps_checked)
    );

    // Receiver: switches at random between stall styles - free flowing, light
    // random, heavy random, and long stall bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            rx_mode      <= 0;
            rx_mode_left <= 64;
            rx_hold      <= 0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(32, 256);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (rx_hold == 0)
                    begin
                        out_stall <= ~out_stall;
                        rx_hold   <= out_stall ? $urandom_range(0, 3) : $urandom_range(1, 20);
                    end
                    else
                        rx_hold <= rx_hold - 1;
                end
            endcase
        end
    end

    function automatic int unsigned clamp_cities(input int unsigned v);
        if (v < 2)
            return 2;
        if (v > CITIES)
            return CITIES;
        return v;
    endfunction

    // Small values make ties common; the extremes show up on their own too.
    function automatic logic [DIST_IN_W-1:0] pick_distance();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return DIST_IN_W'($urandom_range(0, 3));
        if (r == 3)
            return ($urandom_range(0, 1) == 0) ? {DIST_IN_W{1'b0}} : {DIST_IN_W{1'b1}};
        return DIST_IN_W'($urandom);
    endfunction

    // One request on the input channel. Opens a new burst (possibly after a
    // gap) when the old one is used up, then holds the payload until taken.
    // in_valid stays high on return so a follow-up request needs no re-raise.
    task automatic push_request(input op_t op, input logic [CITY_W-1:0] row,
                                input logic [CITY_W-1:0] col,
                                input logic [DIST_IN_W-1:0] dval);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid  <= 1'b0;
                operation <= 1'($urandom_range(0, 1));
                row_city  <= CITY_W'($urandom);
                col_city  <= CITY_W'($urandom);
                distance  <= DIST_IN_W'($urandom);
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        operation <= op;
        row_city  <= row;
        col_city  <= col;
        distance  <= dval;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_entry(input int unsigned row, input int unsigned col,
                              input logic [DIST_IN_W-1:0] dval);
        push_request(OP_LOAD, row[CITY_W-1:0], col[CITY_W-1:0], dval);
        loaded[row*CITIES + col] = 1'b1;
    endtask

    // The table fields ride along with junk; the engine must ignore them.
    task automatic start_tour();
        push_request(OP_RUN, CITY_W'($urandom), CITY_W'($urandom), DIST_IN_W'($urandom));
        tours_sent++;
        if (n_now < n_lo)
            n_lo = n_now;
        if (n_now > n_hi)
            n_hi = n_now;
    endtask

    // Drop valid, wait for every predicted step to drain, then let the
    // engine finish its last cycles so it is idle.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (route_steps_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_city_count(input logic [NCFG_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        n_now = clamp_cities(v);
    endtask

    // Any off-diagonal entry of the active square can be read by a tour,
    // so any hole in it is loaded before the run.
    task automatic fill_square(input int unsigned n);
        for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = 0; c < n; c++)
                if (r != c && !loaded[r*CITIES + c])
                    load_entry(r, c, pick_distance());
    endtask

    initial
    begin
        logic [NCFG_W-1:0] cfg_pick;
        int                sel;
        int                phase;
        int                reloads;

        loaded     = '0;
        burst_left = 0;
        items_sent = 0;
        tours_sent = 0;
        n_now      = clamp_cities(NCITIES_RESET);
        n_lo       = CITIES;
        n_hi       = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: four cities at the reset count ---
        // Ties from city 0 (to 1 and 2) and from city 1 (to 2 and 3) must go
        // to the lower index; the two largest hops give a long tour.
        load_entry(0, 1, 16'd5);
        load_entry(0, 2, 16'd5);
        load_entry(0, 3, 16'hFFFF);
        load_entry(1, 0, 16'hFFFF);
        load_entry(1, 2, 16'd0);
        load_entry(1, 3, 16'd0);
        load_entry(2, 0, 16'd0);
        load_entry(2, 1, 16'd7);
        load_entry(2, 3, 16'hFFFF);
        load_entry(3, 0, 16'hFFFF);
        load_entry(3, 1, 16'd1);
        load_entry(3, 2, 16'd2);
        // diagonal and off-square entries are stored but never walked here
        load_entry(0, 0, 16'hFFFF);
        load_entry(15, 15, 16'd0);
        start_tour();

        // counts below two behave as two; then two and three cities
        write_city_count(5'd0);
        start_tour();
        write_city_count(5'd1);
        start_tour();
        write_city_count(5'd2);
        start_tour();
        write_city_count(5'd3);
        start_tour();
        start_tour();

        // --- random phases: one city count each, a few tours per phase ---
        phase = 0;
        while (items_sent < ITEMS_TARGET)
        begin
            if (phase == 2)
                cfg_pick = 5'd16;
            else if (phase == 6)
                cfg_pick = 5'd31;
            else
            begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    cfg_pick = NCFG_W'($urandom_range(2, 6));
                else if (sel < 8)
                    cfg_pick = NCFG_W'($urandom_range(7, 12));
                else if (sel == 8)
                    cfg_pick = NCFG_W'($urandom_range(13, 31));
                else
                    cfg_pick = NCFG_W'($urandom_range(0, 1));
            end
            write_city_count(cfg_pick);

            repeat ($urandom_range(1, 4))
            begin
                fill_square(n_now);
                // fresh content: mostly inside the square, some anywhere
                reloads = $urandom_range(0, 8);
                repeat (reloads)
                begin
                    if ($urandom_range(0, 3) != 0)
                        load_entry($urandom_range(0, n_now-1), $urandom_range(0, n_now-1),
                                   pick_distance());
                    else
                        load_entry($urandom_range(0, CITIES-1), $urandom_range(0, CITIES-1),
                                   pick_distance());
                end
                start_tour();
            end
            phase++;
        end

        settle();

        $display("Covered %0d requests with %0d tours over %0d to %0d cities;",
                 items_sent, tours_sent, n_lo, n_hi);
        $display("%0d route steps checked, %0d mismatches, %0d steps outstanding",
                 route_steps_checked, mismatch_count, route_steps_left);
        if (mismatch_count == 0 && route_steps_left == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Worst case: every request a sixteen-city tour, whose scan and 17 results
    // wait behind receiver stalls; the limit is set to cover that case.
    initial
    begin
        #8_000_000;
        $display("Timeout: the run did not complete");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
